// ----- rtl/core/scbf_pkg.sv -----
// shared constants and types for the staged commit byte fifo
`default_nettype none

package scbf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 256;
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned COUNT_W       = 9;

   typedef enum logic [2:0] {
      OP_PUSH       = 3'd0,
      OP_FLUSH      = 3'd1,
      OP_POP_MAIN   = 3'd2,
      OP_CLEAR_MAIN = 3'd3,
      OP_POP_STAGED = 3'd4
   } op_type;

endpackage

`default_nettype wire

// ----- rtl/core/scbf_ram.sv -----
// byte wide ring memory, one write port and one registered read port
`default_nettype none

module scbf_ram
   import scbf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [BYTE_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/staged_commit_byte_fifo.sv -----
// Staged commit byte fifo: a staging ring and a main ring of DEPTH bytes each, held in two
// synchronous memories with a registered read port. Push, clear and every failing operation
// load their result from the idle state; a following word is taken in the cycle after only if
// the previous result leaves the output register in that cycle, and no word is taken while a
// result waits there. A pop passes through a pop state, which takes the byte from the
// registered read port of the ring memory. A flush copies one byte per cycle from the staging
// ring read port to the main ring write port; no word is taken meanwhile. A full main ring
// drops its oldest byte for each byte committed past it.
`default_nettype none

module staged_commit_byte_fifo
   import scbf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_operation,
   input  wire logic [BYTE_W-1:0]  req_data_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_ok,
   output logic      [BYTE_W-1:0]  rsp_data_out,
   output logic      [COUNT_W-1:0] rsp_main_count,
   output logic      [COUNT_W-1:0] rsp_staged_count
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP_MAIN,
      S_POP_STAGED,
      S_FLUSH
   } state_type;

   function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] stg_head_ff, stg_head_in, stg_tail_ff, stg_tail_in;
   logic [CW-1:0] stg_fill_ff, stg_fill_in;
   logic [AW-1:0] main_head_ff, main_head_in, main_tail_ff, main_tail_in;
   logic [CW-1:0] main_fill_ff, main_fill_in;
   logic          inflight_ff, inflight_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   logic [BYTE_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] rsp_main_ff, rsp_main_in;
   logic [COUNT_W-1:0] rsp_stg_ff, rsp_stg_in;

   logic              req_fire;
   logic              rsp_load;
   logic              new_ok;
   logic [BYTE_W-1:0] new_data;
   logic              stg_wr_en, main_wr_en;
   logic [BYTE_W-1:0] stg_rd_data, main_rd_data;
   op_type            op;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign op        = op_type'(req_operation);

   scbf_ram #(.DEPTH(DEPTH)) u_stg_ram (
      .clock   (clock),
      .wr_en   (stg_wr_en),
      .wr_addr (stg_tail_ff),
      .wr_data (req_data_byte),
      .rd_addr (stg_head_ff),
      .rd_data (stg_rd_data)
   );

   scbf_ram #(.DEPTH(DEPTH)) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr_en),
      .wr_addr (main_tail_ff),
      .wr_data (stg_rd_data),
      .rd_addr (main_head_ff),
      .rd_data (main_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      stg_head_in  = stg_head_ff;
      stg_tail_in  = stg_tail_ff;
      stg_fill_in  = stg_fill_ff;
      main_head_in = main_head_ff;
      main_tail_in = main_tail_ff;
      main_fill_in = main_fill_ff;
      inflight_in  = 1'b0;
      stg_wr_en    = 1'b0;
      main_wr_en   = 1'b0;
      rsp_load     = 1'b0;
      new_ok       = 1'b0;
      new_data     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_PUSH: begin
                     if (stg_fill_ff != CW'(DEPTH)) begin
                        stg_wr_en   = 1'b1;
                        stg_tail_in = wrap_next(stg_tail_ff);
                        stg_fill_in = stg_fill_ff + 1'b1;
                        new_ok      = 1'b1;
                     end
                     rsp_load = 1'b1;
                  end
                  OP_FLUSH: begin
                     if (stg_fill_ff != '0) begin
                        state_in = S_FLUSH;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_POP_MAIN: begin
                     if (main_fill_ff != '0) begin
                        main_head_in = wrap_next(main_head_ff);
                        main_fill_in = main_fill_ff - 1'b1;
                        state_in     = S_POP_MAIN;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  OP_CLEAR_MAIN: begin
                     main_head_in = '0;
                     main_tail_in = '0;
                     main_fill_in = '0;
                     new_ok       = 1'b1;
                     rsp_load     = 1'b1;
                  end
                  OP_POP_STAGED: begin
                     if (stg_fill_ff != '0) begin
                        stg_head_in = wrap_next(stg_head_ff);
                        stg_fill_in = stg_fill_ff - 1'b1;
                        state_in    = S_POP_STAGED;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         S_POP_MAIN: begin
            new_ok   = 1'b1;
            new_data = main_rd_data;
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         S_POP_STAGED: begin
            new_ok   = 1'b1;
            new_data = stg_rd_data;
            rsp_load = 1'b1;
            state_in = S_IDLE;
         end
         S_FLUSH: begin
            // read side: one staged byte per cycle
            if (stg_fill_ff != '0) begin
               stg_head_in = wrap_next(stg_head_ff);
               stg_fill_in = stg_fill_ff - 1'b1;
               inflight_in = 1'b1;
            end
            // write side: commit the byte read last cycle
            if (inflight_ff) begin
               main_wr_en   = 1'b1;
               main_tail_in = wrap_next(main_tail_ff);
               if (main_fill_ff != CW'(DEPTH)) begin
                  main_fill_in = main_fill_ff + 1'b1;
               end else begin
                  main_head_in = wrap_next(main_head_ff);
               end
            end
            if ((stg_fill_ff == '0) && !inflight_ff) begin
               new_ok   = 1'b1;
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_ok_in   = rsp_ok_ff;
      rsp_data_in = rsp_data_ff;
      rsp_main_in = rsp_main_ff;
      rsp_stg_in  = rsp_stg_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = new_ok;
         rsp_data_in  = new_data;
         rsp_main_in  = COUNT_W'(main_fill_in);
         rsp_stg_in   = COUNT_W'(stg_fill_in);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stg_head_ff  <= '0;
         stg_tail_ff  <= '0;
         stg_fill_ff  <= '0;
         main_head_ff <= '0;
         main_tail_ff <= '0;
         main_fill_ff <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stg_head_ff  <= stg_head_in;
         stg_tail_ff  <= stg_tail_in;
         stg_fill_ff  <= stg_fill_in;
         main_head_ff <= main_head_in;
         main_tail_ff <= main_tail_in;
         main_fill_ff <= main_fill_in;
         inflight_ff  <= inflight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff   <= rsp_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_main_ff <= rsp_main_in;
      rsp_stg_ff  <= rsp_stg_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_data_out     = rsp_data_ff;
   assign rsp_main_count   = rsp_main_ff;
   assign rsp_staged_count = rsp_stg_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (stg_fill_ff <= CW'(DEPTH)) && (main_fill_ff <= CW'(DEPTH)))
      else $error("ring fill count exceeds depth");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready)
      else $error("word accepted while an operation is in progress");

   a_inflight_flush: assert property (@(posedge clock) disable iff (reset)
      inflight_ff |-> (state_ff == S_FLUSH))
      else $error("byte in flight outside a flush");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (op == OP_PUSH) && (stg_fill_ff != CW'(DEPTH)))
      |=> (stg_fill_ff == $past(stg_fill_ff) + 1'b1))
      else $error("accepted push did not grow the staging ring");

   a_flush_drains: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FLUSH) && (state_in == S_IDLE)) |-> (stg_fill_ff == '0))
      else $error("flush finished with bytes still staged");
`endif

endmodule

`default_nettype wire
